>>> src/gtphl_pkg.sv
package gtphl_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF  = 16383;
  localparam int unsigned GTP_HEADER_BYTES_DEF = 8;

  localparam logic [7:0]  GTP_FLAGS_RESET = 8'h30;

  localparam int unsigned ETH_HDR_BYTES  = 14;
  localparam int unsigned VLAN_TAG_BYTES = 4;
  localparam int unsigned IP_MIN_BYTES   = 20;
  localparam int unsigned UDP_HDR_BYTES  = 8;
  localparam int unsigned IP_PROTO_POS   = 9;
  localparam int unsigned TYPE_HI_POS    = 12;
  localparam int unsigned TYPE_LO_POS    = 13;
  localparam int unsigned INNER_HI_POS   = 16;
  localparam int unsigned INNER_LO_POS   = 17;

  localparam logic [15:0] TPID_VLAN      = 16'h8100;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4   = 4'd4;
  localparam logic [7:0]  UDP_PROTO_NUM  = 8'd17;

  // register map, word index
  localparam logic REG_GTP_FLAGS = 1'b0;

  typedef enum logic [3:0] {
    FAIL_NONE,
    FAIL_SHORT_ETH,
    FAIL_NOT_IPV4,
    FAIL_SHORT_IP,
    FAIL_BAD_VERSION,
    FAIL_NOT_UDP,
    FAIL_SHORT_UDP,
    FAIL_SHORT_GTP,
    FAIL_BAD_FLAGS
  } fail_code_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [6:0] gtp_offset;
    logic [3:0] fail_code;
  } out_item_t;

endpackage

>>> src/gtpv1_header_locator_core.sv
// A last-byte item's result is registered: the item passes the input register, then
// the result register, which loads only once the output is free.
// Throughput: one byte item per cycle, set by the single per-byte compare stage;
// a waiting result stops intake only once a last-byte item reaches the input register.
// Reset: asynchronous; clears all frame state and valids, flags register to 0x30.
module gtpv1_header_locator_core
  import gtphl_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES  = MAX_FRAME_BYTES_DEF,
  parameter int unsigned GTP_HEADER_BYTES = GTP_HEADER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned LW = CW + 1;

  // configuration
  logic [7:0] flags_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= GTP_FLAGS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_GTP_FLAGS) begin
      flags_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_GTP_FLAGS) ? {24'd0, flags_q} : 32'd0;

  // input register and handshake
  logic      s1_valid_q;
  in_item_t  s1_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      out_free;
  logic      s1_adv;
  logic      fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = !s1_q.last_byte || out_free;
  assign fire       = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_item_i;
    end
  end

  // frame state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    thb_q, thb_d;
  logic          vlan_q, vlan_d;
  logic          ipv4_q, ipv4_d;
  logic          ver_q, ver_d;
  logic          udp_q, udp_d;
  logic [6:0]    gtp_q, gtp_d;
  logic          fmatch_q, fmatch_d;

  logic [4:0]    ip_start;
  logic [15:0]   etype;
  logic [LW-1:0] len;
  fail_code_e    code;

  always_comb begin
    cnt_d    = cnt_q;
    thb_d    = thb_q;
    vlan_d   = vlan_q;
    ipv4_d   = ipv4_q;
    ver_d    = ver_q;
    udp_d    = udp_q;
    gtp_d    = gtp_q;
    fmatch_d = fmatch_q;
    ip_start = vlan_q ? 5'(ETH_HDR_BYTES + VLAN_TAG_BYTES) : 5'(ETH_HDR_BYTES);
    etype    = {thb_q, s1_q.data_byte};

    if (cnt_q < CW'(MAX_FRAME_BYTES)) begin
      if (cnt_q == CW'(TYPE_HI_POS)) begin
        thb_d = s1_q.data_byte;
      end else if (cnt_q == CW'(TYPE_LO_POS)) begin
        if (etype == TPID_VLAN) begin
          vlan_d   = 1'b1;
          ip_start = 5'(ETH_HDR_BYTES + VLAN_TAG_BYTES);
        end else begin
          ipv4_d = (etype == ETHERTYPE_IPV4);
        end
      end else if (vlan_q && cnt_q == CW'(INNER_HI_POS)) begin
        thb_d = s1_q.data_byte;
      end else if (vlan_q && cnt_q == CW'(INNER_LO_POS)) begin
        ipv4_d = (etype == ETHERTYPE_IPV4);
      end else if (cnt_q >= CW'(ETH_HDR_BYTES)) begin
        if (cnt_q == CW'(ip_start)) begin
          ver_d = (s1_q.data_byte[7:4] == IP_VERSION_4);
          gtp_d = 7'(ip_start) + 7'({s1_q.data_byte[3:0], 2'b00}) + 7'(UDP_HDR_BYTES);
        end else if (cnt_q > CW'(ip_start)) begin
          if (cnt_q == CW'(ip_start) + CW'(IP_PROTO_POS)) begin
            udp_d = (s1_q.data_byte == UDP_PROTO_NUM);
          end
          if (cnt_q == CW'(gtp_q)) begin
            fmatch_d = (s1_q.data_byte == flags_q);
          end
        end
      end
      cnt_d = cnt_q + CW'(1);
    end

    // checks in priority order, on the updated frame state
    len = LW'(cnt_q) + LW'(1);
    if (len < LW'(ETH_HDR_BYTES)) begin
      code = FAIL_SHORT_ETH;
    end else if (vlan_d && len < LW'(ETH_HDR_BYTES + VLAN_TAG_BYTES)) begin
      code = FAIL_SHORT_ETH;
    end else if (!ipv4_d) begin
      code = FAIL_NOT_IPV4;
    end else if (len < LW'(ip_start) + LW'(IP_MIN_BYTES)) begin
      code = FAIL_SHORT_IP;
    end else if (!ver_d) begin
      code = FAIL_BAD_VERSION;
    end else if (!udp_d) begin
      code = FAIL_NOT_UDP;
    end else if (len < LW'(gtp_d)) begin
      code = FAIL_SHORT_UDP;
    end else if (len < LW'(gtp_d) + LW'(GTP_HEADER_BYTES)) begin
      code = FAIL_SHORT_GTP;
    end else if (!fmatch_d) begin
      code = FAIL_BAD_FLAGS;
    end else begin
      code = FAIL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      thb_q    <= '0;
      vlan_q   <= 1'b0;
      ipv4_q   <= 1'b0;
      ver_q    <= 1'b0;
      udp_q    <= 1'b0;
      gtp_q    <= '0;
      fmatch_q <= 1'b0;
    end else if (fire) begin
      if (s1_q.last_byte) begin
        cnt_q    <= '0;
        thb_q    <= '0;
        vlan_q   <= 1'b0;
        ipv4_q   <= 1'b0;
        ver_q    <= 1'b0;
        udp_q    <= 1'b0;
        gtp_q    <= '0;
        fmatch_q <= 1'b0;
      end else begin
        cnt_q    <= cnt_d;
        thb_q    <= thb_d;
        vlan_q   <= vlan_d;
        ipv4_q   <= ipv4_d;
        ver_q    <= ver_d;
        udp_q    <= udp_d;
        gtp_q    <= gtp_d;
        fmatch_q <= fmatch_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire && s1_q.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && fire && s1_q.last_byte) begin
      out_q.found      <= (code == FAIL_NONE);
      out_q.gtp_offset <= (code == FAIL_NONE) ? gtp_d : 7'd0;
      out_q.fail_code  <= code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks; IHL of zero puts the GTP header right after the UDP header
  a_found_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |->
      out_item_o.fail_code == FAIL_NONE &&
      out_item_o.gtp_offset >= 7'(ETH_HDR_BYTES + UDP_HDR_BYTES))
    else $error("found result with bad code or offset");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |->
      out_item_o.fail_code != FAIL_NONE && out_item_o.gtp_offset == 7'd0)
    else $error("failed result with nonzero offset or ok code");

  a_cnt_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_FRAME_BYTES))
    else $error("byte count beyond saturation");

  a_frame_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_q.last_byte |=> cnt_q == '0 && !vlan_q && gtp_q == '0 && out_valid_o)
    else $error("frame state not cleared after last byte");

  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_q))
    else $error("stalled input register changed");

endmodule

>>> tb/tb_gtpv1_header_locator_core.sv
`timescale 1ns / 100ps

module tb_gtpv1_header_locator_core;
  import gtphl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 300;
  // low saturation point keeps the long-frame test short
  localparam int unsigned FRAME_LIMIT = 128;
  localparam logic [2:0]  FLAGS_ADDR  = {REG_GTP_FLAGS, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  gtpv1_header_locator_core #(
    .MAX_FRAME_BYTES (FRAME_LIMIT)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // locator state as the block should hold it
  logic [7:0]  flags_cfg = GTP_FLAGS_RESET;
  logic [13:0] bytes_seen = '0;
  logic [7:0]  type_hi = '0;
  bit          tag_seen, ipv4_ok, ver_ok, udp_ok, flags_ok;
  logic [6:0]  gtp_pos = '0;

  out_item_t   verdict_q[$];
  logic [7:0]  frame_bytes[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  bit          hold_start = 1'b0;

  function automatic void clear_frame_state();
    bytes_seen = '0;
    type_hi    = '0;
    tag_seen   = 1'b0;
    ipv4_ok    = 1'b0;
    ver_ok     = 1'b0;
    udp_ok     = 1'b0;
    gtp_pos    = '0;
    flags_ok   = 1'b0;
  endfunction

  function automatic void locate_gtp_byte(input in_item_t item, output bit done,
                                          output out_item_t verdict);
    int unsigned n, ip_at, len;
    logic [7:0]  b;
    fail_code_e  code;
    b     = item.data_byte;
    n     = bytes_seen;
    ip_at = tag_seen ? ETH_HDR_BYTES + VLAN_TAG_BYTES : ETH_HDR_BYTES;
    done  = 1'b0;
    verdict = '0;
    if (n < FRAME_LIMIT) begin
      if (n == TYPE_HI_POS) begin
        type_hi = b;
      end else if (n == TYPE_LO_POS) begin
        if ({type_hi, b} == TPID_VLAN) begin
          tag_seen = 1'b1;
          ip_at    = ETH_HDR_BYTES + VLAN_TAG_BYTES;
        end else begin
          ipv4_ok = ({type_hi, b} == ETHERTYPE_IPV4);
        end
      end else if (tag_seen && n == INNER_HI_POS) begin
        type_hi = b;
      end else if (tag_seen && n == INNER_LO_POS) begin
        ipv4_ok = ({type_hi, b} == ETHERTYPE_IPV4);
      end else if (n >= ETH_HDR_BYTES) begin
        if (n == ip_at) begin
          ver_ok  = (b[7:4] == IP_VERSION_4);
          gtp_pos = 7'(ip_at + b[3:0] * 4 + UDP_HDR_BYTES);
        end else if (n > ip_at) begin
          if (n == ip_at + IP_PROTO_POS) udp_ok = (b == UDP_PROTO_NUM);
          if (n == gtp_pos) flags_ok = (b == flags_cfg);
        end
      end
      bytes_seen = 14'(n + 1);
    end
    if (!item.last_byte) return;

    len = n + 1;
    if (len < ETH_HDR_BYTES) code = FAIL_SHORT_ETH;
    else if (tag_seen && len < ETH_HDR_BYTES + VLAN_TAG_BYTES) code = FAIL_SHORT_ETH;
    else if (!ipv4_ok) code = FAIL_NOT_IPV4;
    else if (len < ip_at + IP_MIN_BYTES) code = FAIL_SHORT_IP;
    else if (!ver_ok) code = FAIL_BAD_VERSION;
    else if (!udp_ok) code = FAIL_NOT_UDP;
    else if (len < gtp_pos) code = FAIL_SHORT_UDP;
    else if (len < gtp_pos + GTP_HEADER_BYTES_DEF) code = FAIL_SHORT_GTP;
    else if (!flags_ok) code = FAIL_BAD_FLAGS;
    else code = FAIL_NONE;

    done               = 1'b1;
    verdict.found      = (code == FAIL_NONE);
    verdict.gtp_offset = (code == FAIL_NONE) ? gtp_pos : 7'd0;
    verdict.fail_code  = code;
    clear_frame_state();
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: stall level changes every span, plus a long hold on request
  always @(posedge clk) begin : rx_stalls
    int unsigned span, stall_pct, hold_left;
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (span == 0) begin
      span = $urandom_range(16, 128);
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    span--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    mismatches++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        $error("result item with no frame pending");
      end else begin
        want = verdict_q.pop_front();
        if (out_item.found !== want.found)
          report_field("found", want.found, out_item.found);
        if (out_item.gtp_offset !== want.gtp_offset)
          report_field("gtp_offset", want.gtp_offset, out_item.gtp_offset);
        if (out_item.fail_code !== want.fail_code)
          report_field("fail_code", want.fail_code, out_item.fail_code);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t  item;
    out_item_t verdict;
    bit        done;
    int        gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(1, 6) : 0;
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    item = '{data_byte: b, last_byte: last};
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    locate_gtp_byte(item, done, verdict);
    if (done) verdict_q.push_back(verdict);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_flags(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FLAGS_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    flags_cfg = value;
  endtask

  task automatic check_flags_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FLAGS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== flags_cfg) begin
      mismatches++;
      $error("gtp_flags_expected: expected %0d, got %0d", flags_cfg, prdata[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int unsigned gtp_end(input bit has_tag, input logic [3:0] ihl);
    return (has_tag ? ETH_HDR_BYTES + VLAN_TAG_BYTES : ETH_HDR_BYTES) + ihl * 4 +
           UDP_HDR_BYTES + GTP_HEADER_BYTES_DEF;
  endfunction

  // well-formed GTP-U/UDP/IPv4 frame cut or padded to len bytes
  task automatic build_frame(input bit has_tag, input logic [3:0] ihl,
                             input int unsigned len);
    int unsigned ip_at, gtp_at;
    logic [7:0]  b;
    ip_at  = has_tag ? ETH_HDR_BYTES + VLAN_TAG_BYTES : ETH_HDR_BYTES;
    gtp_at = ip_at + ihl * 4 + UDP_HDR_BYTES;
    frame_bytes.delete();
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (i == TYPE_HI_POS) b = has_tag ? TPID_VLAN[15:8] : ETHERTYPE_IPV4[15:8];
      else if (i == TYPE_LO_POS) b = has_tag ? TPID_VLAN[7:0] : ETHERTYPE_IPV4[7:0];
      else if (has_tag && i == INNER_HI_POS) b = ETHERTYPE_IPV4[15:8];
      else if (has_tag && i == INNER_LO_POS) b = ETHERTYPE_IPV4[7:0];
      else if (i == ip_at) b = {IP_VERSION_4, ihl};
      else if (i == ip_at + IP_PROTO_POS) b = UDP_PROTO_NUM;
      else if (i == gtp_at) b = flags_cfg;
      frame_bytes.push_back(b);
    end
  endtask

  task automatic test_flags_register();
    check_flags_readback();
    write_flags(8'h00);
    check_flags_readback();
    build_frame(1'b0, 4'd5, gtp_end(1'b0, 4'd5));
    send_frame();
    wait_idle();
    write_flags(8'hFF);
    check_flags_readback();
    build_frame(1'b1, 4'd5, gtp_end(1'b1, 4'd5));
    send_frame();
    build_frame(1'b0, 4'd5, gtp_end(1'b0, 4'd5));
    frame_bytes[gtp_end(1'b0, 4'd5) - GTP_HEADER_BYTES_DEF] = GTP_FLAGS_RESET;
    send_frame();
    wait_idle();
    write_flags(GTP_FLAGS_RESET);
  endtask

  task automatic test_header_checks();
    build_frame(1'b0, 4'd5, gtp_end(1'b0, 4'd5));
    send_frame();
    build_frame(1'b1, 4'd5, gtp_end(1'b1, 4'd5) + 7);
    send_frame();
    // deepest header: tag plus IHL 15
    build_frame(1'b1, 4'd15, gtp_end(1'b1, 4'd15));
    send_frame();
    // IHL below 5, UDP header overlapping the IP header
    build_frame(1'b0, 4'd0, gtp_end(1'b0, 4'd0) + 4);
    send_frame();
    build_frame(1'b1, 4'd1, gtp_end(1'b1, 4'd1));
    send_frame();
    build_frame(1'b0, 4'd5, 60);
    frame_bytes[TYPE_HI_POS] = 8'h86;
    frame_bytes[TYPE_LO_POS] = 8'hDD;
    send_frame();
    // second tag behind the first
    build_frame(1'b1, 4'd5, 60);
    frame_bytes[INNER_HI_POS] = TPID_VLAN[15:8];
    frame_bytes[INNER_LO_POS] = TPID_VLAN[7:0];
    send_frame();
    build_frame(1'b0, 4'd5, 60);
    frame_bytes[ETH_HDR_BYTES] = 8'h65;
    send_frame();
    build_frame(1'b0, 4'd5, 60);
    frame_bytes[ETH_HDR_BYTES + IP_PROTO_POS] = 8'h06;
    send_frame();
    build_frame(1'b0, 4'd5, gtp_end(1'b0, 4'd5));
    frame_bytes[gtp_end(1'b0, 4'd5) - GTP_HEADER_BYTES_DEF] = ~flags_cfg;
    send_frame();
    wait_idle();
  endtask

  task automatic test_length_checks();
    build_frame(1'b0, 4'd5, 1);
    send_frame();
    build_frame(1'b0, 4'd5, ETH_HDR_BYTES - 1);
    send_frame();
    build_frame(1'b0, 4'd5, ETH_HDR_BYTES);
    send_frame();
    // tag seen but frame ends inside it
    build_frame(1'b1, 4'd5, ETH_HDR_BYTES + VLAN_TAG_BYTES - 1);
    send_frame();
    build_frame(1'b1, 4'd5, ETH_HDR_BYTES + VLAN_TAG_BYTES);
    send_frame();
    build_frame(1'b0, 4'd5, ETH_HDR_BYTES + IP_MIN_BYTES - 1);
    send_frame();
    build_frame(1'b0, 4'd5, ETH_HDR_BYTES + IP_MIN_BYTES);
    send_frame();
    build_frame(1'b0, 4'd15, 50);
    send_frame();
    build_frame(1'b0, 4'd5, gtp_end(1'b0, 4'd5) - 1);
    send_frame();
    build_frame(1'b1, 4'd5, gtp_end(1'b1, 4'd5) - GTP_HEADER_BYTES_DEF);
    send_frame();
    wait_idle();
  endtask

  task automatic test_long_frame();
    sender_gaps = 1'b0;
    build_frame(1'b1, 4'd5, FRAME_LIMIT + 17);
    send_frame();
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    hold_start  = 1'b1;
    repeat (60) begin
      build_frame(1'b0, 4'd5, $urandom_range(1, 2));
      send_frame();
    end
    wait_idle();
    sender_gaps = 1'b1;
  endtask

  task automatic random_frame();
    int unsigned kind, full, len;
    bit          has_tag;
    logic [3:0]  ihl;
    kind    = $urandom_range(0, 99);
    has_tag = 1'($urandom_range(0, 1));
    ihl     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
    full    = gtp_end(has_tag, ihl);
    len     = (kind < 10) ? $urandom_range(1, full) : full + $urandom_range(0, 12);
    build_frame(has_tag, ihl, len);
    if (kind >= 85) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 90)) frame_bytes.push_back(8'($urandom));
    end else if (kind >= 70) begin
      frame_bytes[$urandom_range(0, len - 1)] = 8'($urandom);
    end else if ($urandom_range(0, 4) == 0 && len > full - GTP_HEADER_BYTES_DEF) begin
      frame_bytes[full - GTP_HEADER_BYTES_DEF] = 8'($urandom);
    end
  endtask

  task automatic test_random_frames();
    int unsigned start_bytes;
    logic [7:0]  cfg;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       cfg = 8'h00;
        1:       cfg = 8'hFF;
        2:       cfg = 8'($urandom);
        default: cfg = GTP_FLAGS_RESET;
      endcase
      write_flags(cfg);
      sender_gaps = (phase != 2);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 40) begin
        random_frame();
        send_frame();
      end
      wait_idle();
    end
  endtask

  initial begin
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_flags_register();
    test_header_checks();
    test_length_checks();
    test_long_frame();
    test_backpressure();
    test_random_frames();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/gtphl_pkg.sv
src/gtpv1_header_locator_core.sv
tb/tb_gtpv1_header_locator_core.sv
